@@ rtl/stb_pkg.sv @@
`default_nettype none

package stb_pkg;

    // default bank size
    localparam int NUM_TIMERS_DEF = 8;

    // command codes
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_START_ONCE = 3'd1;
    localparam logic [2:0] CMD_START_AUTO = 3'd2;
    localparam logic [2:0] CMD_STOP       = 3'd3;
    localparam logic [2:0] CMD_CHECK      = 3'd4;
    localparam logic [2:0] CMD_DELAY      = 3'd5;

    // tick divider wraps after this many processed ticks
    localparam logic [3:0] TICKS_PER_SLOW_PULSE = 4'd10;
    // shortest delay that is loaded
    localparam logic [31:0] MIN_DELAY = 32'd2;

    // input transaction
    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  timer_id;
        logic [31:0] period;
    } stb_item_t;

    // result transaction
    typedef struct packed {
        logic check_expired;
        logic delay_done;
        logic pulse_1ms;
        logic pulse_10ms;
    } stb_result_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic sweep;
    } stb_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic tick_go;
    } stb_status_t;

endpackage

`default_nettype wire

@@ rtl/stb_ctrl.sv @@
`default_nettype none

module stb_ctrl #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    output logic                 done,
    output stb_pkg::stb_ctl_t    ctl,
    output logic [IDX_W-1:0]     idx,
    input  stb_pkg::stb_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             done_reg, done_next;

    // next state and strobe
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.tick_go)
                begin
                    state_next = ST_SWEEP;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_SWEEP:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // command decode
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign idx       = idx_reg;
    assign ctl.load  = start && (state_reg == ST_IDLE);
    assign ctl.exec  = (state_reg == ST_EXEC);
    assign ctl.sweep = (state_reg == ST_SWEEP);

endmodule

`default_nettype wire

@@ rtl/stb_datapath.sv @@
`default_nettype none

module stb_datapath #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  stb_pkg::stb_item_t    item,
    input  wire                   cfg_we,
    input  wire                   cfg_data,
    input  stb_pkg::stb_ctl_t     ctl,
    input  wire [IDX_W-1:0]       idx,
    output stb_pkg::stb_status_t  status,
    output stb_pkg::stb_result_t  result
);

    localparam logic [7:0] NUM_ID = 8'(NUM_TIMERS);

    // timer bank
    logic [31:0]           count_reg  [NUM_TIMERS];
    logic [31:0]           reload_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] expired_reg;
    logic [NUM_TIMERS-1:0] auto_reg;

    logic [31:0] delay_count_reg, delay_count_next;
    logic        delay_flag_reg, delay_flag_next;
    logic [3:0]  divider_reg, divider_next;
    logic        tick_enable_reg;

    stb_pkg::stb_item_t   item_reg;
    stb_pkg::stb_result_t result_reg, result_next;

    logic [IDX_W-1:0] addr;
    logic             id_valid;
    logic [31:0]      cnt_rd, rld_rd, cnt_dec;
    logic             exp_rd, auto_rd;
    logic             ent_we;
    logic [31:0]      cnt_wr, rld_wr;
    logic             exp_wr, auto_wr;
    logic [3:0]       divider_inc;

    // entry selection: sweep index or addressed timer
    assign id_valid = (item_reg.timer_id < NUM_ID);
    assign addr     = ctl.sweep ? idx : item_reg.timer_id[IDX_W-1:0];
    assign cnt_rd   = count_reg[addr];
    assign rld_rd   = reload_reg[addr];
    assign exp_rd   = expired_reg[addr];
    assign auto_rd  = auto_reg[addr];
    assign cnt_dec  = cnt_rd - 32'd1;
    assign divider_inc = divider_reg + 4'd1;

    assign status.tick_go = (item_reg.command == stb_pkg::CMD_TICK) && tick_enable_reg;

    // per-command update
    always_comb
    begin
        ent_we           = 1'b0;
        cnt_wr           = cnt_rd;
        rld_wr           = rld_rd;
        exp_wr           = exp_rd;
        auto_wr          = auto_rd;
        delay_count_next = delay_count_reg;
        delay_flag_next  = delay_flag_reg;
        divider_next     = divider_reg;
        result_next      = '0;
        if (ctl.sweep)
        begin
            ent_we = 1'b1;
            if (cnt_rd != 32'd0)
            begin
                cnt_wr = cnt_dec;
                if (cnt_dec == 32'd0)
                begin
                    exp_wr = 1'b1;
                    if (auto_rd)
                    begin
                        cnt_wr = rld_rd;
                    end
                end
            end
        end
        else if (ctl.exec)
        begin
            case (item_reg.command)
                stb_pkg::CMD_TICK:
                begin
                    if (tick_enable_reg)
                    begin
                        if (delay_count_reg != 32'd0)
                        begin
                            delay_count_next = delay_count_reg - 32'd1;
                            if (delay_count_reg == 32'd1)
                            begin
                                delay_flag_next = 1'b1;
                            end
                        end
                        result_next.pulse_1ms = 1'b1;
                        divider_next = divider_inc;
                        if (divider_inc >= stb_pkg::TICKS_PER_SLOW_PULSE)
                        begin
                            divider_next           = 4'd0;
                            result_next.pulse_10ms = 1'b1;
                        end
                    end
                end
                stb_pkg::CMD_START_ONCE,
                stb_pkg::CMD_START_AUTO:
                begin
                    if (id_valid)
                    begin
                        ent_we  = 1'b1;
                        cnt_wr  = item_reg.period;
                        rld_wr  = item_reg.period;
                        exp_wr  = 1'b0;
                        auto_wr = (item_reg.command == stb_pkg::CMD_START_AUTO);
                    end
                end
                stb_pkg::CMD_STOP:
                begin
                    if (id_valid)
                    begin
                        ent_we  = 1'b1;
                        cnt_wr  = 32'd0;
                        exp_wr  = 1'b0;
                        auto_wr = 1'b0;
                    end
                end
                stb_pkg::CMD_CHECK:
                begin
                    if (id_valid && exp_rd)
                    begin
                        ent_we                   = 1'b1;
                        exp_wr                   = 1'b0;
                        result_next.check_expired = 1'b1;
                    end
                end
                stb_pkg::CMD_DELAY:
                begin
                    if (item_reg.period != 32'd0)
                    begin
                        delay_count_next = (item_reg.period == 32'd1) ?
                                           stb_pkg::MIN_DELAY : item_reg.period;
                        delay_flag_next  = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        result_next.delay_done = delay_flag_next;
    end

    // bank and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i]  <= '0;
                reload_reg[i] <= '0;
            end
            expired_reg     <= '0;
            auto_reg        <= '0;
            delay_count_reg <= '0;
            delay_flag_reg  <= 1'b0;
            divider_reg     <= '0;
            tick_enable_reg <= 1'b0;
        end
        else
        begin
            if (ent_we)
            begin
                count_reg[addr]   <= cnt_wr;
                reload_reg[addr]  <= rld_wr;
                expired_reg[addr] <= exp_wr;
                auto_reg[addr]    <= auto_wr;
            end
            delay_count_reg <= delay_count_next;
            delay_flag_reg  <= delay_flag_next;
            divider_reg     <= divider_next;
            if (cfg_we)
            begin
                tick_enable_reg <= cfg_data;
            end
        end
    end

    // transaction and result capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= item;
        end
        if (ctl.exec)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

@@ rtl/software_timer_bank.sv @@
// sequence: start enters EXEC, and the registered done strobes as EXEC ends,
//   or, for an enabled tick, once the sweep has updated every timer in turn
// a new transaction is taken only while idle, not while busy is high
// busy falls in the cycle done strobes, so the next start can be taken there
// done is a one-cycle strobe and the receiver cannot stall it
// reset: asynchronous, clears all timers, the delay counter, divider and tick_enable
`default_nettype none

module software_timer_bank #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  stb_pkg::stb_item_t   item,
    output logic                 done,
    output stb_pkg::stb_result_t result,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire                  cfg_data
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    stb_pkg::stb_ctl_t    ctl;
    stb_pkg::stb_status_t status;
    logic [IDX_W-1:0]     idx;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    stb_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .ctl    (ctl),
        .idx    (idx),
        .status (status)
    );

    stb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .ctl      (ctl),
        .idx      (idx),
        .status   (status),
        .result   (result)
    );

endmodule

`default_nettype wire
